// ===== src/tld_pkg.sv =====
// Shared types and constants for the type/length deframer.
`default_nettype none
package tld_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 32;
    localparam int HIDX_W = 3;

    localparam logic [BYTE_W-1:0] TYPE_DEFAULT = 8'h01;
    localparam logic [HIDX_W-1:0] HEADER_LEN   = 3'd5;
    localparam logic [HIDX_W-1:0] HIDX_TYPE    = 3'd0;
    localparam logic [HIDX_W-1:0] HIDX_FIRST   = 3'd1;

    typedef struct packed {
        logic              last;
        logic [BYTE_W-1:0] payload;
    } t_result;

endpackage
`default_nettype wire

// ===== src/tld_parser.sv =====
// Header parser and payload counter: one byte per step, at most one result.
`default_nettype none
module tld_parser (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_step,
    input  wire  [tld_pkg::BYTE_W-1:0]   i_byte,
    input  wire  [tld_pkg::BYTE_W-1:0]   i_accepted_type,
    output logic                         o_res_valid,
    output tld_pkg::t_result             o_res
);
    import tld_pkg::*;

    logic [HIDX_W-1:0] r_hidx,  n_hidx;
    logic [BYTE_W-1:0] r_ptype, n_ptype;
    logic [LEN_W-1:0]  r_len,   n_len;
    logic [LEN_W-1:0]  r_rem,   n_rem;
    logic              in_payload;

    assign in_payload = (r_rem != '0);

    always_comb begin
        n_hidx      = r_hidx;
        n_ptype     = r_ptype;
        n_len       = r_len;
        n_rem       = r_rem;
        o_res_valid = 1'b0;
        o_res.payload = i_byte;
        o_res.last    = (r_rem == LEN_W'(1));
        if (in_payload) begin
            n_rem       = r_rem - LEN_W'(1);
            o_res_valid = i_step && (r_ptype == i_accepted_type);
        end else if (r_hidx == HIDX_TYPE) begin
            n_ptype = i_byte;
            n_len   = '0;
            n_hidx  = HIDX_FIRST;
        end else if (r_hidx < HEADER_LEN - HIDX_FIRST) begin
            n_len  = {r_len[LEN_W-BYTE_W-1:0], i_byte};
            n_hidx = r_hidx + HIDX_FIRST;
        end else begin
            // final length byte (or stray index) closes the header
            n_len  = {r_len[LEN_W-BYTE_W-1:0], i_byte};
            n_rem  = n_len;
            n_hidx = HIDX_TYPE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hidx  <= HIDX_TYPE;
            r_ptype <= '0;
            r_len   <= '0;
            r_rem   <= '0;
        end else if (i_step) begin
            r_hidx  <= n_hidx;
            r_ptype <= n_ptype;
            r_len   <= n_len;
            r_rem   <= n_rem;
        end
    end

endmodule
`default_nettype wire

// ===== src/tld_out_fifo.sv =====
// Two-entry result buffer driving the master side.
`default_nettype none
module tld_out_fifo (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  tld_pkg::t_result    i_data,
    output logic                o_full,
    output logic                o_valid,
    input  wire                 i_ready,
    output tld_pkg::t_result    o_data
);
    import tld_pkg::*;

    t_result     r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== src/type_length_deframer.sv =====
// Top level: byte-stream type/length deframer.
//
//  Port group      Dir   Contents
//  s_axis_*        in    tdata[7:0] = stream_byte
//  m_axis_*        out   tdata[7:0] = payload_byte, tlast = last_of_packet
//  i_cfg_*         in    wdata[7:0] = accepted_type (reset 0x01)
//
// One byte per cycle sustained while the master side keeps up; an accepted byte
// passes through the input register, then the parser pushes its result into a
// two-entry output buffer, from which the master side takes it.
// Synchronous active-low reset clears the header state and both buffers.
// A stalled master side fills the output buffer, then the input register,
// then drops s_axis_tready; m_axis_tready never reaches s_axis_tready directly.
`default_nettype none
module type_length_deframer (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire  [tld_pkg::BYTE_W-1:0]   s_axis_tdata,   // [7:0] stream_byte
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [tld_pkg::BYTE_W-1:0]   m_axis_tdata,   // [7:0] payload_byte
    output logic                         m_axis_tlast,
    input  wire                          i_cfg_we,
    input  wire  [tld_pkg::BYTE_W-1:0]   i_cfg_wdata
);
    import tld_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic [BYTE_W-1:0] r_acc_type;
    logic              step;
    logic              fifo_full;
    logic              res_valid;
    t_result           res;
    t_result           out_res;

    assign step          = r_in_valid && !fifo_full;
    assign s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_acc_type <= TYPE_DEFAULT;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (i_cfg_we) begin
                r_acc_type <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    tld_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_byte          (r_in_byte),
        .i_accepted_type (r_acc_type),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    tld_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_full  (fifo_full),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (out_res)
    );

    assign m_axis_tdata = out_res.payload;
    assign m_axis_tlast = out_res.last;

endmodule
`default_nettype wire
